### src/mmfs_pkg.sv
// shared types, constants and codes for the min-max feature scaler
`timescale 1ns / 1ps

package mmfs_pkg;

    // field widths
    localparam int DATA_W   = 16;
    localparam int OP_W     = 2;
    localparam int FIDX_W   = 4;
    localparam int ST_W     = 2;
    localparam int CFG_IDX_W = 1;

    // default feature count
    localparam int NUM_FEATURES_DEF = 16;

    // serial divider sizes: unsigned dividend and divisor magnitudes
    localparam int DVD_W = 32;
    localparam int DVS_W = 16;

    // configuration reset values
    localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 16'sd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_FIT = 2'd0,
        OP_FWD = 2'd1,
        OP_INV = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SPAN = 2'd1,
        ST_SATURATED = 2'd2,
        ST_UNFITTED  = 2'd3
    } stat_code_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load;
        logic mul;
        logic div_start;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_calc;
        logic div_busy;
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

### src/mmfs_in_if.sv
// input item channel: operation, feature index, value and first-sample flag
`timescale 1ns / 1ps

interface mmfs_in_if;
    logic                              valid;
    logic                              ready;
    logic [mmfs_pkg::OP_W-1:0]         opcode;
    logic [mmfs_pkg::FIDX_W-1:0]       feature_index;
    logic signed [mmfs_pkg::DATA_W-1:0] sample_value;
    logic                              first_sample;

    modport source (
        output valid, opcode, feature_index, sample_value, first_sample,
        input  ready
    );
    modport sink (
        input  valid, opcode, feature_index, sample_value, first_sample,
        output ready
    );
endinterface

### src/mmfs_out_if.sv
// result channel: scaled value and status
`timescale 1ns / 1ps

interface mmfs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mmfs_pkg::DATA_W-1:0] result_value;
    logic [mmfs_pkg::ST_W-1:0]         status;

    modport source (
        output valid, result_value, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

### src/mmfs_cfg_if.sv
// configuration write channel: register index and write data
`timescale 1ns / 1ps

interface mmfs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mmfs_pkg::CFG_IDX_W-1:0]     index;
    logic [mmfs_pkg::DATA_W-1:0]        data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### src/mmfs_divider.sv
// radix-4 restoring unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps

module mmfs_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mmfs_pkg::DVD_W-1:0]   dividend,
    input  logic [mmfs_pkg::DVS_W-1:0]   divisor,
    output logic [mmfs_pkg::DVD_W-1:0]   quotient,
    output logic                         busy,
    output logic                         done
);

    localparam int DVD_W = mmfs_pkg::DVD_W;
    localparam int DVS_W = mmfs_pkg::DVS_W;
    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DVS_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   r1, r2, r1_sub, r2_sub;
    logic [DVS_W-1:0] r1_res;
    logic             ge1, ge2;

    // two dependent shift-subtract steps
    always_comb
    begin
        r1     = {r_reg, q_reg[DVD_W-1]};
        r1_sub = r1 - {1'b0, d_reg};
        ge1    = (r1 >= {1'b0, d_reg});
        r1_res = ge1 ? r1_sub[DVS_W-1:0] : r1[DVS_W-1:0];
        r2     = {r1_res, q_reg[DVD_W-2]};
        r2_sub = r2 - {1'b0, d_reg};
        ge2    = (r2 >= {1'b0, d_reg});
        r_next = ge2 ? r2_sub[DVS_W-1:0] : r2[DVS_W-1:0];
        q_next = {q_reg[DVD_W-3:0], ge1, ge2};
    end

    // control: iteration counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == CNT_W'(STEPS - 1));

    // divider goes idle right after its last step
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg)
        else $error("divider still busy after last step");

endmodule

### src/mmfs_datapath.sv
// datapath: range registers, feature statistics, multiplier, divider, output register
`timescale 1ns / 1ps

module mmfs_datapath #(
    parameter int NUM_FEATURES = mmfs_pkg::NUM_FEATURES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmfs_pkg::ctrl_cmd_t                 cmd,
    output mmfs_pkg::ctrl_stat_t                stat,
    input  logic [mmfs_pkg::OP_W-1:0]           opcode,
    input  logic [mmfs_pkg::FIDX_W-1:0]         feature_index,
    input  logic signed [mmfs_pkg::DATA_W-1:0]  sample_value,
    input  logic                                first_sample,
    input  logic                                cfg_valid,
    input  logic [mmfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmfs_pkg::DATA_W-1:0]         cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mmfs_pkg::DATA_W-1:0]  result_value,
    output logic [mmfs_pkg::ST_W-1:0]           status
);

    localparam int DATA_W = mmfs_pkg::DATA_W;
    localparam int FIDX_W = mmfs_pkg::FIDX_W;
    localparam int DVD_W  = mmfs_pkg::DVD_W;
    localparam int DVS_W  = mmfs_pkg::DVS_W;
    localparam int OPR_W  = DATA_W + 1;
    localparam int PRD_W  = 2 * OPR_W;
    localparam int SUM_W  = PRD_W + 1;
    // only indexes the input field can name need storage
    localparam int DEPTH  = (NUM_FEATURES < (1 << FIDX_W)) ? NUM_FEATURES : (1 << FIDX_W);
    localparam int IX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    // item and configuration registers
    mmfs_pkg::op_t              op_reg;
    logic [FIDX_W-1:0]          idx_reg;
    logic signed [DATA_W-1:0]   v_reg;
    logic                       first_reg;
    logic signed [DATA_W-1:0]   rlo_reg;
    logic signed [DATA_W-1:0]   rhi_reg;

    // feature statistics
    logic signed [DATA_W-1:0]   min_reg [DEPTH];
    logic signed [DATA_W-1:0]   max_reg [DEPTH];
    logic [DEPTH-1:0]           fitted_reg;

    // arithmetic operands and intermediate results
    logic signed [OPR_W-1:0]    a_reg, b_reg, c_reg;
    logic signed [DATA_W-1:0]   off_reg;
    logic signed [PRD_W-1:0]    prod_reg;
    logic                       neg_reg;
    logic                       calc_reg;
    logic signed [DATA_W-1:0]   early_res_reg;
    mmfs_pkg::stat_code_t       early_st_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   res_out_reg;
    mmfs_pkg::stat_code_t       st_out_reg;

    logic [IX_W-1:0]            ix;
    logic                       idx_ok;
    logic                       fitted;
    logic signed [DATA_W-1:0]   mn, mx;
    logic signed [OPR_W-1:0]    span, rspan, a_fwd, a_inv;
    logic                       need_calc;
    logic signed [DATA_W-1:0]   early_res_next;
    mmfs_pkg::stat_code_t       early_st_next;

    logic [PRD_W-1:0]           abs_prod;
    logic [OPR_W-1:0]           abs_c;
    logic [DVD_W-1:0]           div_dividend;
    logic [DVD_W-1:0]           quotient;
    logic                       div_busy, div_done;

    logic signed [PRD_W-1:0]    q_signed;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DATA_W-1:0]   res_next;
    mmfs_pkg::stat_code_t       st_next;
    logic                       out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rlo_reg <= mmfs_pkg::RANGE_LOW_RST;
            rhi_reg <= mmfs_pkg::RANGE_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mmfs_pkg::CFG_RANGE_LOW:  rlo_reg <= cfg_data;
                mmfs_pkg::CFG_RANGE_HIGH: rhi_reg <= cfg_data;
            endcase
        end
    end

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= mmfs_pkg::op_t'(opcode);
            idx_reg   <= feature_index;
            v_reg     <= sample_value;
            first_reg <= first_sample;
        end
    end

    // statistics lookup and operand selection
    always_comb
    begin
        ix     = idx_reg[IX_W-1:0];
        idx_ok = (32'(idx_reg) < NUM_FEATURES);
        mn     = min_reg[ix];
        mx     = max_reg[ix];
        fitted = idx_ok && fitted_reg[ix];
        span   = {mx[DATA_W-1], mx} - {mn[DATA_W-1], mn};
        rspan  = {rhi_reg[DATA_W-1], rhi_reg} - {rlo_reg[DATA_W-1], rlo_reg};
        a_fwd  = {v_reg[DATA_W-1], v_reg} - {mn[DATA_W-1], mn};
        a_inv  = {v_reg[DATA_W-1], v_reg} - {rlo_reg[DATA_W-1], rlo_reg};

        need_calc      = 1'b0;
        early_res_next = '0;
        early_st_next  = mmfs_pkg::ST_OK;
        unique case (op_reg)
            mmfs_pkg::OP_FWD:
            begin
                if (!fitted)
                begin
                    early_st_next = mmfs_pkg::ST_UNFITTED;
                end
                else if (span == '0)
                begin
                    early_res_next = rlo_reg;
                    early_st_next  = mmfs_pkg::ST_ZERO_SPAN;
                end
                else
                begin
                    need_calc = 1'b1;
                end
            end
            mmfs_pkg::OP_INV:
            begin
                if (!fitted)
                begin
                    early_st_next = mmfs_pkg::ST_UNFITTED;
                end
                else if (rspan == '0)
                begin
                    early_res_next = mn;
                    early_st_next  = mmfs_pkg::ST_ZERO_SPAN;
                end
                else
                begin
                    need_calc = 1'b1;
                end
            end
            default:
            begin
                early_res_next = '0;
                early_st_next  = mmfs_pkg::ST_OK;
            end
        endcase
    end

    // fit: fold the sample into min and max
    always_ff @(posedge clk)
    begin
        if (cmd.load && (op_reg == mmfs_pkg::OP_FIT) && idx_ok)
        begin
            if (first_reg || !fitted_reg[ix])
            begin
                min_reg[ix] <= v_reg;
                max_reg[ix] <= v_reg;
            end
            else
            begin
                if (v_reg < mn)
                begin
                    min_reg[ix] <= v_reg;
                end
                if (v_reg > mx)
                begin
                    max_reg[ix] <= v_reg;
                end
            end
        end
    end

    // fitted flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fitted_reg <= '0;
        end
        else if (cmd.load && (op_reg == mmfs_pkg::OP_FIT) && idx_ok)
        begin
            fitted_reg[ix] <= 1'b1;
        end
    end

    // operand, offset and early result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            calc_reg      <= need_calc;
            early_res_reg <= early_res_next;
            early_st_reg  <= early_st_next;
            if (op_reg == mmfs_pkg::OP_INV)
            begin
                a_reg   <= a_inv;
                b_reg   <= span;
                c_reg   <= rspan;
                off_reg <= mn;
            end
            else
            begin
                a_reg   <= a_fwd;
                b_reg   <= rspan;
                c_reg   <= span;
                off_reg <= rlo_reg;
            end
        end
    end

    // product
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= a_reg * b_reg;
        end
    end

    // magnitudes and rounding bias for the divider
    always_comb
    begin
        abs_prod     = prod_reg[PRD_W-1] ? PRD_W'(-prod_reg) : PRD_W'(prod_reg);
        abs_c        = c_reg[OPR_W-1] ? OPR_W'(-c_reg) : OPR_W'(c_reg);
        div_dividend = abs_prod[DVD_W-1:0] + DVD_W'(abs_c[DVS_W-1:1]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= prod_reg[PRD_W-1] ^ c_reg[OPR_W-1];
        end
    end

    mmfs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (abs_c[DVS_W-1:0]),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // sign, offset and saturation
    always_comb
    begin
        q_signed = neg_reg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
        sum      = {q_signed[PRD_W-1], q_signed}
                 + {{(SUM_W-DATA_W){off_reg[DATA_W-1]}}, off_reg};
        if (!calc_reg)
        begin
            res_next = early_res_reg;
            st_next  = early_st_reg;
        end
        else if (sum > SAT_HI)
        begin
            res_next = 16'sh7fff;
            st_next  = mmfs_pkg::ST_SATURATED;
        end
        else if (sum < SAT_LO)
        begin
            res_next = 16'sh8000;
            st_next  = mmfs_pkg::ST_SATURATED;
        end
        else
        begin
            res_next = sum[DATA_W-1:0];
            st_next  = mmfs_pkg::ST_OK;
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_out_reg <= res_next;
            st_out_reg  <= st_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_out_reg;
    assign status       = st_out_reg;

    assign stat.need_calc = need_calc;
    assign stat.div_busy  = div_busy;
    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;

    // divider is only started when free
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // a finished item shows up in the output register
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished item not presented");

    // saturated results sit at an end of the range
    a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (st_out_reg == mmfs_pkg::ST_SATURATED)
        |-> (res_out_reg == 16'sh7fff) || (res_out_reg == 16'sh8000))
        else $error("saturated result not clamped");

endmodule

### src/mmfs_ctrl.sv
// controller: sequences accept, lookup and output per item, with multiply and divide when arithmetic is needed
`timescale 1ns / 1ps

module mmfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mmfs_pkg::ctrl_stat_t  stat,
    output mmfs_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL  = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = stat.need_calc ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // waiting on the divider only while it runs
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> stat.div_busy)
        else $error("controller waiting on idle divider");

endmodule

### src/min_max_feature_scaler.sv
// top level: per-feature min-max scaler in signed Q8.8
// forward and inverse: accept, load, multiply, divider start, divide, then finish;
//   fit, no-op, zero-span and unfitted transactions go from load straight to finish
// one transaction is handled at a time; finish waits for a free output register;
//   the radix-4 serial divider (16 steps for a 32-bit dividend) is the slowest part
// a new transaction is taken while the previous result waits in the output register
// reset: asynchronous active low; range_low 0, range_high 256 (1.0), all features unfitted
`timescale 1ns / 1ps

module min_max_feature_scaler #(
    parameter int NUM_FEATURES = mmfs_pkg::NUM_FEATURES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mmfs_in_if.sink        sample,
    mmfs_out_if.source     result,
    mmfs_cfg_if.sink       cfg
);

    mmfs_pkg::ctrl_cmd_t   cmd;
    mmfs_pkg::ctrl_stat_t  stat;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    // controller
    mmfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    mmfs_datapath #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (sample.opcode),
        .feature_index (sample.feature_index),
        .sample_value  (sample.sample_value),
        .first_sample  (sample.first_sample),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .result_value  (result.result_value),
        .status        (result.status)
    );

endmodule
